// File: hdl/fbc_pkg.sv
// Package: shared constants, operation codes and queue entry type for the box culler.
`default_nettype none
package fbc_pkg;

    // Field and coordinate widths
    localparam int FIELD_W     = 32;
    localparam int COORD_W_DEF = 32;
    localparam int COORD_W_MAX = 48;

    // Store sizes
    localparam int NUM_PLANES  = 6;
    localparam int NUM_CORNERS = 8;
    localparam int NUM_AXES    = 3;

    // Q16.16 offset scale shift
    localparam int FRAC_BITS = 16;

    // Input operation codes
    localparam logic [1:0] OP_LOAD_PLANE  = 2'd0;
    localparam logic [1:0] OP_LOAD_CORNER = 2'd1;
    localparam logic [1:0] OP_TEST_BOX    = 2'd2;

    // Queue entry kinds
    localparam logic [1:0] KIND_PLANE  = 2'd0;
    localparam logic [1:0] KIND_CORNER = 2'd1;
    localparam logic [1:0] KIND_TEST   = 2'd2;

    typedef logic [FIELD_W-1:0] field_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] slot;
        field_t     ax;
        field_t     ay;
        field_t     az;
        field_t     d;
        field_t     bx;
        field_t     by;
        field_t     bz;
    } entry_t;

endpackage
`default_nettype wire

// File: hdl/fbc_if.sv
// Interfaces: input item channel and result channel.
`default_nettype none
interface fbc_in_if;
    import fbc_pkg::*;

    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [2:0] slot;
    field_t     first_x;
    field_t     first_y;
    field_t     first_z;
    field_t     plane_offset;
    field_t     second_x;
    field_t     second_y;
    field_t     second_z;

    modport source (
        output valid, operation, slot, first_x, first_y, first_z,
               plane_offset, second_x, second_y, second_z,
        input  ready
    );
    modport sink (
        input  valid, operation, slot, first_x, first_y, first_z,
               plane_offset, second_x, second_y, second_z,
        output ready
    );
endinterface

interface fbc_out_if;
    logic valid;
    logic ready;
    logic visible;

    modport source (output valid, visible, input ready);
    modport sink (input valid, visible, output ready);
endinterface
`default_nettype wire

// File: hdl/fbc_front.sv
// Front end: accept input items, classify them and push queue entries.
`default_nettype none
module fbc_front (
    fbc_in_if.sink           in,
    input  wire logic        queue_full,
    output fbc_pkg::entry_t  push_entry,
    output logic             push
);
    import fbc_pkg::*;

    logic keep;

    // Accept whenever the queue has room
    assign in.ready = !queue_full;

    // Drop unused codes and plane loads to slots six and seven
    always_comb
    begin
        keep = 1'b0;
        case (in.operation)
            OP_LOAD_PLANE:  keep = (32'(in.slot) < NUM_PLANES);
            OP_LOAD_CORNER: keep = 1'b1;
            OP_TEST_BOX:    keep = 1'b1;
            default:        keep = 1'b0;
        endcase
    end

    // Build the entry
    always_comb
    begin
        push_entry.kind = KIND_TEST;
        case (in.operation)
            OP_LOAD_PLANE:  push_entry.kind = KIND_PLANE;
            OP_LOAD_CORNER: push_entry.kind = KIND_CORNER;
            default:        push_entry.kind = KIND_TEST;
        endcase
        push_entry.slot = in.slot;
        push_entry.ax   = in.first_x;
        push_entry.ay   = in.first_y;
        push_entry.az   = in.first_z;
        push_entry.d    = in.plane_offset;
        push_entry.bx   = in.second_x;
        push_entry.by   = in.second_y;
        push_entry.bz   = in.second_z;
    end

    assign push = in.valid && in.ready && keep;

endmodule
`default_nettype wire

// File: hdl/fbc_queue.sv
// Two-entry queue between front and back.
`default_nettype none
module fbc_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire fbc_pkg::entry_t  push_entry,
    input  wire logic             pop,
    output fbc_pkg::entry_t       head,
    output logic                  full,
    output logic                  not_empty
);
    import fbc_pkg::*;

    entry_t     mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign head      = mem_reg[rd_ptr_reg];
    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);

    // Store pushed entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule
`default_nettype wire

// File: hdl/fbc_back.sv
// Back end: plane and corner stores, plane-by-plane box test, result register.
`default_nettype none
module fbc_back #(
    parameter int COORD_WIDTH = fbc_pkg::COORD_W_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire fbc_pkg::entry_t  head,
    input  wire logic             not_empty,
    output logic                  pop,
    fbc_out_if.source             out
);
    import fbc_pkg::*;

    localparam int PW = 2 * COORD_WIDTH;
    localparam int SW = 2 * COORD_WIDTH + 3;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MUL   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [PW-1:0]          prod_t;

    coord_t plane_n_reg [NUM_PLANES][NUM_AXES];
    coord_t plane_d_reg [NUM_PLANES];
    coord_t corner_reg  [NUM_CORNERS][NUM_AXES];
    coord_t bmin_reg    [NUM_AXES];
    coord_t bmax_reg    [NUM_AXES];

    logic [1:0] state_reg;
    logic [2:0] plane_cnt_reg;
    prod_t      plo_reg [NUM_AXES];
    prod_t      phi_reg [NUM_AXES];
    coord_t     pd_reg;
    logic       mv_reg;
    logic       cull_reg;
    logic       out_vld_reg;
    logic       vis_reg;

    coord_t     head_a [NUM_AXES];
    coord_t     head_b [NUM_AXES];
    prod_t      pmin   [NUM_AXES];
    logic signed [SW-1:0] plane_sum;
    logic       plane_out;
    logic       axis_cull;
    logic       out_free;

    // Take a 32-bit field to the coordinate width, sign at bit COORD_WIDTH-1
    function automatic coord_t to_coord(input field_t f);
        logic [COORD_W_MAX-1:0] z;
        z = COORD_W_MAX'(f);
        return coord_t'(z[COORD_WIDTH-1:0]);
    endfunction

    assign head_a[0] = to_coord(head.ax);
    assign head_a[1] = to_coord(head.ay);
    assign head_a[2] = to_coord(head.az);
    assign head_b[0] = to_coord(head.bx);
    assign head_b[1] = to_coord(head.by);
    assign head_b[2] = to_coord(head.bz);

    assign pop      = (state_reg == S_IDLE) && not_empty;
    assign out_free = !out_vld_reg || out.ready;

    // Smallest plane sum over the box corners, minus the scaled offset
    always_comb
    begin
        for (int k = 0; k < NUM_AXES; k++)
        begin
            pmin[k] = (plo_reg[k] < phi_reg[k]) ? plo_reg[k] : phi_reg[k];
        end
        plane_sum = SW'(pmin[0]) + SW'(pmin[1]) + SW'(pmin[2])
                  - (SW'(pd_reg) <<< FRAC_BITS);
        plane_out = (plane_sum > 0);
    end

    // All frustum corners beyond one box face
    always_comb
    begin
        logic all_above;
        logic all_below;
        axis_cull = 1'b0;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            all_above = 1'b1;
            all_below = 1'b1;
            for (int c = 0; c < NUM_CORNERS; c++)
            begin
                all_above &= (corner_reg[c][a] > bmax_reg[a]);
                all_below &= (corner_reg[c][a] < bmin_reg[a]);
            end
            axis_cull |= all_above | all_below;
        end
    end

    // Stores: write loads as they leave the queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_PLANES; p++)
            begin
                plane_d_reg[p] <= '0;
                for (int k = 0; k < NUM_AXES; k++)
                begin
                    plane_n_reg[p][k] <= '0;
                end
            end
            for (int c = 0; c < NUM_CORNERS; c++)
            begin
                for (int k = 0; k < NUM_AXES; k++)
                begin
                    corner_reg[c][k] <= '0;
                end
            end
        end
        else if (pop)
        begin
            case (head.kind)
                KIND_PLANE:
                begin
                    for (int k = 0; k < NUM_AXES; k++)
                    begin
                        plane_n_reg[head.slot][k] <= head_a[k];
                    end
                    plane_d_reg[head.slot] <= to_coord(head.d);
                end
                KIND_CORNER:
                begin
                    for (int k = 0; k < NUM_AXES; k++)
                    begin
                        corner_reg[head.slot][k] <= head_a[k];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Box and product registers
    always_ff @(posedge clk)
    begin
        if (pop && (head.kind == KIND_TEST))
        begin
            for (int k = 0; k < NUM_AXES; k++)
            begin
                bmin_reg[k] <= head_a[k];
                bmax_reg[k] <= head_b[k];
            end
        end
        for (int k = 0; k < NUM_AXES; k++)
        begin
            plo_reg[k] <= plane_n_reg[plane_cnt_reg][k] * bmin_reg[k];
            phi_reg[k] <= plane_n_reg[plane_cnt_reg][k] * bmax_reg[k];
        end
        pd_reg <= plane_d_reg[plane_cnt_reg];
        vis_reg <= (state_reg == S_OUT && out_free) ? !(cull_reg | axis_cull) : vis_reg;
    end

    // Sequencer: one plane per cycle, then drain and deliver
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            plane_cnt_reg <= '0;
            mv_reg        <= 1'b0;
            cull_reg      <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            mv_reg <= (state_reg == S_MUL);
            if (mv_reg && plane_out)
            begin
                cull_reg <= 1'b1;
            end
            if (out_vld_reg && out.ready)
            begin
                out_vld_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    plane_cnt_reg <= '0;
                    if (pop && (head.kind == KIND_TEST))
                    begin
                        cull_reg  <= 1'b0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    if (32'(plane_cnt_reg) == NUM_PLANES - 1)
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        plane_cnt_reg <= plane_cnt_reg + 3'd1;
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_vld_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out.valid   = out_vld_reg;
    assign out.visible = vis_reg;

endmodule
`default_nettype wire

// File: hdl/frustum_box_cull.sv
// Frustum box culler: six planes, eight frustum corners, one visible bit per box test.
// Load items are written to the stores as they leave the queue; a test holds the back end
// while it works one plane per cycle through three shared multiplier pairs, then drains
// and delivers the result (waiting while the previous one is not taken) before it takes another item.
// A two-entry queue lets the front accept while the back works.
// Reset (rst_n low, asynchronous) clears both stores, the queue and the result valid flag.
`default_nettype none
module frustum_box_cull #(
    parameter int COORD_WIDTH = fbc_pkg::COORD_W_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    fbc_in_if.sink     in,
    fbc_out_if.source  out
);
    import fbc_pkg::*;

    entry_t push_entry;
    entry_t head;
    logic   push;
    logic   pop;
    logic   queue_full;
    logic   not_empty;

    // Classify and push
    fbc_front u_front (
        .in         (in),
        .queue_full (queue_full),
        .push_entry (push_entry),
        .push       (push)
    );

    // Decouple front and back
    fbc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (queue_full),
        .not_empty  (not_empty)
    );

    // Execute loads and tests
    fbc_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .not_empty (not_empty),
        .pop       (pop),
        .out       (out)
    );

endmodule
`default_nettype wire

// File: tb/tb_frustum_box_cull.sv
// Testbench for frustum_box_cull: directed and random items checked against a built-in culling predictor.
`default_nettype none
module tb_frustum_box_cull;
    import fbc_pkg::*;

    typedef logic signed [31:0] coord_t;

    // Operation code that the block ignores
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic clk;
    logic rst_n;

    fbc_in_if  in_ch ();
    fbc_out_if out_ch ();

    frustum_box_cull i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_ch),
        .out   (out_ch)
    );

    // Predictor state: planes and frustum corners
    coord_t plane_n [NUM_PLANES][3];
    coord_t plane_d [NUM_PLANES];
    coord_t corner_pos [NUM_CORNERS][3];

    logic   visible_q [$];
    int     errors;
    int     burst_left;
    int     hold_off_cycles;
    logic   hold_off_req;

    // Clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // True when n.p - d*2^16 > 0, computed exactly
    function automatic logic beyond_plane(input int p, input coord_t x, input coord_t y,
                                          input coord_t z);
        logic signed [127:0] acc;
        longint              prod;
        begin
            prod = longint'(plane_n[p][0]) * longint'(x);
            acc  = prod;
            prod = longint'(plane_n[p][1]) * longint'(y);
            acc  = acc + prod;
            prod = longint'(plane_n[p][2]) * longint'(z);
            acc  = acc + prod;
            prod = longint'(plane_d[p]) <<< FRAC_BITS;
            acc  = acc - prod;
            return acc > 0;
        end
    endfunction

    function automatic logic box_visible(input coord_t lo [3], input coord_t hi [3]);
        int     outs;
        int     above;
        int     below;
        coord_t x;
        coord_t y;
        coord_t z;
        begin
            // Cull on any plane that has all box corners outside
            for (int p = 0; p < NUM_PLANES; p++)
            begin
                outs = 0;
                for (int c = 0; c < 8; c++)
                begin
                    x = c[0] ? hi[0] : lo[0];
                    y = c[1] ? hi[1] : lo[1];
                    z = c[2] ? hi[2] : lo[2];
                    if (beyond_plane(p, x, y, z))
                        outs++;
                end
                if (outs == 8)
                    return 1'b0;
            end
            // Cull when all frustum corners lie beyond one box face
            for (int a = 0; a < NUM_AXES; a++)
            begin
                above = 0;
                below = 0;
                for (int c = 0; c < NUM_CORNERS; c++)
                begin
                    if (corner_pos[c][a] > hi[a]) above++;
                    if (corner_pos[c][a] < lo[a]) below++;
                end
                if (above == NUM_CORNERS || below == NUM_CORNERS)
                    return 1'b0;
            end
            return 1'b1;
        end
    endfunction

    // Update predictor for one accepted item
    task automatic apply_item(input logic [1:0] op, input logic [2:0] sl,
                              input coord_t fx, input coord_t fy, input coord_t fz,
                              input coord_t d, input coord_t sx, input coord_t sy,
                              input coord_t sz);
        coord_t lo [3];
        coord_t hi [3];
        begin
            lo[0] = fx; lo[1] = fy; lo[2] = fz;
            hi[0] = sx; hi[1] = sy; hi[2] = sz;
            if (op == OP_LOAD_PLANE)
            begin
                if (sl < NUM_PLANES)
                begin
                    plane_n[sl][0] = fx;
                    plane_n[sl][1] = fy;
                    plane_n[sl][2] = fz;
                    plane_d[sl]    = d;
                end
            end
            else if (op == OP_LOAD_CORNER)
            begin
                corner_pos[sl][0] = fx;
                corner_pos[sl][1] = fy;
                corner_pos[sl][2] = fz;
            end
            else if (op == OP_TEST_BOX)
                visible_q.push_back(box_visible(lo, hi));
        end
    endtask

    // Send one item, with bursts and random gaps in between
    task automatic send_item(input logic [1:0] op, input logic [2:0] sl,
                             input coord_t fx, input coord_t fy, input coord_t fz,
                             input coord_t d, input coord_t sx, input coord_t sy,
                             input coord_t sz);
        int gap;
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0)
                begin
                    in_ch.valid = 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            burst_left--;
            in_ch.operation    = op;
            in_ch.slot         = sl;
            in_ch.first_x      = fx;
            in_ch.first_y      = fy;
            in_ch.first_z      = fz;
            in_ch.plane_offset = d;
            in_ch.second_x     = sx;
            in_ch.second_y     = sy;
            in_ch.second_z     = sz;
            in_ch.valid        = 1'b1;
            do
                @(posedge clk);
            while (!in_ch.ready);
            apply_item(op, sl, fx, fy, fz, d, sx, sy, sz);
            @(negedge clk);
        end
    endtask

    task automatic test_box(input coord_t lx, input coord_t ly, input coord_t lz,
                            input coord_t hx, input coord_t hy, input coord_t hz);
        send_item(OP_TEST_BOX, 3'($urandom), lx, ly, lz, coord_t'($urandom), hx, hy, hz);
    endtask

    // Random coordinate: extremes, small values or full range
    function automatic coord_t rand_coord(input int span);
        int sel;
        begin
            sel = $urandom_range(0, 19);
            if (sel == 0) return 32'sh8000_0000;
            if (sel == 1) return 32'sh7fff_ffff;
            if (sel == 2) return 0;
            if (sel < 5)  return coord_t'($urandom);
            return coord_t'($urandom_range(0, 2 * span)) - coord_t'(span);
        end
    endfunction

    // Receiver: stall pattern plus one long hold-off on request
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready    <= 1'b0;
            hold_off_cycles <= 0;
        end
        else if (hold_off_req && hold_off_cycles == 0)
        begin
            out_ch.ready    <= 1'b0;
            hold_off_cycles <= 300;
        end
        else if (hold_off_cycles > 1)
        begin
            out_ch.ready    <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            out_ch.ready <= ($urandom_range(0, 3) != 0);
    end

    // Check each result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (visible_q.size() == 0)
            begin
                $display("%0t: unexpected result visible=%0b", $time, out_ch.visible);
                errors++;
            end
            else
            begin
                if (out_ch.visible !== visible_q[0])
                begin
                    $display("%0t: visible mismatch expected=%0b actual=%0b", $time,
                             visible_q[0], out_ch.visible);
                    errors++;
                end
                void'(visible_q.pop_front());
            end
        end
    end

    // Reset stores: zero planes never cull, corners sit at the origin
    task automatic test_reset_stores();
        test_box(-65536, -65536, -65536, 65536, 65536, 65536);
        test_box(65536, 0, 0, 131072, 65536, 65536);
        test_box(-131072, -1, 5, -65536, 1, 9);
    endtask

    // Plane loads, ignored plane slots and plane culling
    task automatic test_planes();
        send_item(OP_LOAD_PLANE, 3'd0, 65536, 0, 0, 65536, 0, 0, 0);
        test_box(131072, 0, 0, 196608, 1, 1);
        test_box(65536, 0, 0, 65536, 0, 0);
        send_item(OP_LOAD_PLANE, 3'd6, -65536, 0, 0, 32'sh7fff_ffff, 0, 0, 0);
        send_item(OP_LOAD_PLANE, 3'd7, 0, -65536, 0, 32'sh8000_0000, 0, 0, 0);
        test_box(-65536, -65536, -65536, 0, 0, 0);
        send_item(OP_LOAD_PLANE, 3'd5, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                  32'sh7fff_ffff, 0, 0, 0);
        test_box(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
        test_box(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    endtask

    // Corner loads, axis culling and an inverted box
    task automatic test_corners();
        for (int c = 0; c < NUM_CORNERS; c++)
            send_item(OP_LOAD_CORNER, 3'(c), c[0] ? 65536 : -65536, c[1] ? 65536 : -65536,
                      c[2] ? 65536 : -65536, -1, -1, -1, -1);
        test_box(-655360, -655360, 131072, 655360, 655360, 262144);
        test_box(0, 0, 0, 0, 0, 0);
        test_box(65536, 65536, 65536, -65536, -65536, -65536);
    endtask

    // Unused operation code changes nothing and gives no result
    task automatic test_unused_op();
        send_item(OP_UNUSED, 3'd0, 32'sh8000_0000, 0, 0, 0, 0, 0, 0);
        test_box(-1, -1, -1, 1, 1, 1);
    endtask

    // Random frusta and boxes
    task automatic test_random(input int count);
        int     sel;
        coord_t lx;
        coord_t ly;
        coord_t lz;
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 8)
                send_item(OP_LOAD_PLANE, 3'($urandom), rand_coord(65536), rand_coord(65536),
                          rand_coord(65536), rand_coord(1 << 22), coord_t'($urandom),
                          coord_t'($urandom), coord_t'($urandom));
            else if (sel < 16)
                send_item(OP_LOAD_CORNER, 3'($urandom), rand_coord(1 << 22),
                          rand_coord(1 << 22), rand_coord(1 << 22), coord_t'($urandom),
                          coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
            else if (sel < 18)
                send_item(OP_UNUSED, 3'($urandom), coord_t'($urandom), coord_t'($urandom),
                          coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                          coord_t'($urandom), coord_t'($urandom));
            else if (sel < 24)
                test_box(rand_coord(1 << 30), rand_coord(1 << 30), rand_coord(1 << 30),
                         rand_coord(1 << 30), rand_coord(1 << 30), rand_coord(1 << 30));
            else
            begin
                // Well-formed box near the frustum
                lx = rand_coord(1 << 23);
                ly = rand_coord(1 << 23);
                lz = rand_coord(1 << 23);
                test_box(lx, ly, lz, lx + coord_t'($urandom_range(0, 1 << 21)),
                         ly + coord_t'($urandom_range(0, 1 << 21)),
                         lz + coord_t'($urandom_range(0, 1 << 21)));
            end
        end
    endtask

    // Long receiver hold-off while the sender keeps offering
    task automatic test_pressure();
        hold_off_req = 1'b1;
        wait (hold_off_cycles != 0);
        hold_off_req = 1'b0;
        for (int i = 0; i < 20; i++)
            test_box(rand_coord(1 << 22), rand_coord(1 << 22), rand_coord(1 << 22),
                     rand_coord(1 << 22), rand_coord(1 << 22), rand_coord(1 << 22));
    endtask

    // Main sequence
    initial
    begin
        errors       = 0;
        burst_left   = 0;
        hold_off_req = 1'b0;
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            plane_n[p][0] = 0;
            plane_n[p][1] = 0;
            plane_n[p][2] = 0;
            plane_d[p]    = 0;
        end
        for (int c = 0; c < NUM_CORNERS; c++)
            for (int a = 0; a < 3; a++)
                corner_pos[c][a] = 0;
        in_ch.valid        = 1'b0;
        in_ch.operation    = OP_LOAD_PLANE;
        in_ch.slot         = '0;
        in_ch.first_x      = '0;
        in_ch.first_y      = '0;
        in_ch.first_z      = '0;
        in_ch.plane_offset = '0;
        in_ch.second_x     = '0;
        in_ch.second_y     = '0;
        in_ch.second_z     = '0;
        rst_n              = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_stores();
        test_planes();
        test_corners();
        test_unused_op();
        test_random(700);
        test_pressure();
        test_random(800);

        in_ch.valid = 1'b0;
        wait (visible_q.size() == 0);
        repeat (30) @(posedge clk);
        if (errors == 0 && visible_q.size() == 0)
            $display("tb_frustum_box_cull OK");
        else
            $display("tb_frustum_box_cull NOT OK");
        $finish;
    end

    // Timeout
    initial
    begin
        #20000000;
        $display("tb_frustum_box_cull NOT OK");
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
hdl/fbc_pkg.sv
hdl/fbc_if.sv
hdl/fbc_front.sv
hdl/fbc_queue.sv
hdl/fbc_back.sv
hdl/frustum_box_cull.sv
tb/tb_frustum_box_cull.sv
